// ===== rtl/core/ewv_pkg.sv =====
package ewv_pkg;

    // Word length limit and counter width (counter saturates at MAX_WORD_LEN + 1)
    localparam int MAX_WORD_LEN = 75;
    localparam int CNT_W        = $clog2(MAX_WORD_LEN + 2);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORD_LEN);

    // Result field widths
    localparam int STATUS_W = 4;
    localparam int OFFSET_W = 7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NO_OPEN       = 4'd2;
    localparam logic [STATUS_W-1:0] ST_CHARSET_EMPTY = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CHARSET_BAD   = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NO_CS_DELIM   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_ENCODING  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NO_ENC_DELIM  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NO_CLOSE      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_TEXT_EMPTY    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_TEXT_BAD      = 4'd10;
    localparam logic [STATUS_W-1:0] ST_Q_HEX         = 4'd11;
    localparam logic [STATUS_W-1:0] ST_B_CHAR        = 4'd12;
    localparam logic [STATUS_W-1:0] ST_B_LENGTH      = 4'd13;
    localparam logic [STATUS_W-1:0] ST_B_PADDING     = 4'd14;

    // Character constants
    localparam logic [7:0] CH_PRINT_LO = 8'd33;
    localparam logic [7:0] CH_PRINT_HI = 8'd126;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SLASH    = 8'h2F;

    // Per-byte classification flags
    typedef struct packed {
        logic tok;     // charset token character
        logic hex;     // hex digit
        logic b64;     // base64 alphabet, no pad
        logic qtext;   // printable, not '?'
        logic enc_q;   // Q or q
        logic enc_b;   // B or b
        logic qmark;   // '?'
        logic equal;   // '='
    } char_class_t;

endpackage

// ===== rtl/core/ewv_in_if.sv =====
interface ewv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] word_byte;
    logic       last_byte;

    modport source (output valid, output word_byte, output last_byte, input ready);
    modport sink   (input valid, input word_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ewv_out_if.sv =====
interface ewv_out_if;
    logic                          valid;
    logic                          ready;
    logic [ewv_pkg::STATUS_W-1:0]  status;
    logic [ewv_pkg::OFFSET_W-1:0]  error_offset;

    modport source (output valid, output status, output error_offset, input ready);
    modport sink   (input valid, input status, input error_offset, output ready);
endinterface

// ===== rtl/core/ewv_classify.sv =====
module ewv_classify (
    input  logic [7:0]           ch,
    output ewv_pkg::char_class_t cls
);
    import ewv_pkg::*;

    logic printable;
    logic special;

    // Token specials: ( ) < > @ , ; : \ " / [ ] ? =
    always_comb
    begin
        unique case (ch)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
            8'h5C, 8'h22, CH_SLASH, 8'h5B, 8'h5D, CH_QMARK, CH_EQUAL: special = 1'b1;
            default: special = 1'b0;
        endcase
    end

    assign printable = (ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI);

    assign cls.tok   = printable && !special;
    assign cls.hex   = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h46) ||
                       (ch >= 8'h61 && ch <= 8'h66);
    assign cls.b64   = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
                       (ch >= 8'h30 && ch <= 8'h39) || ch == CH_PLUS || ch == CH_SLASH;
    assign cls.qtext = printable && (ch != CH_QMARK);
    assign cls.enc_q = (ch == 8'h51) || (ch == 8'h71);
    assign cls.enc_b = (ch == 8'h42) || (ch == 8'h62);
    assign cls.qmark = (ch == CH_QMARK);
    assign cls.equal = (ch == CH_EQUAL);

endmodule

// ===== rtl/core/encoded_word_validator.sv =====
// Encoded-word validator: one byte per transfer, one result per word.
// Result path: the last byte is held in the input register, then parse logic
// loads the result register from it (a pending result can stall that load).
// Throughput: one byte per cycle; a pending result only stalls the next word's
// last byte (and the bytes behind it), all other bytes keep flowing.
// Reset (rst_n low, async): parser state cleared, input and result stages empty.
module encoded_word_validator (
    input  logic       clk,
    input  logic       rst_n,
    ewv_in_if.sink     word_ch,
    ewv_out_if.source  result_ch
);
    import ewv_pkg::*;

    typedef enum logic [2:0] {
        PH_OPEN, PH_CS_FIRST, PH_CS_REST, PH_ENC, PH_ENC_DELIM, PH_TEXT, PH_HALT
    } phase_t;

    // Input stage
    logic                s1_valid_reg;
    logic [7:0]          s1_byte_reg;
    logic                s1_last_reg;

    // Parser state
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          d0_reg, d0_next;
    logic [7:0]          d1_reg, d1_next;
    phase_t              phase_reg, phase_next;
    logic                b64_reg, b64_next;
    logic [1:0]          pad_reg, pad_next;
    logic [1:0]          esc_reg, esc_next;
    logic [1:0]          mod4_reg, mod4_next;
    logic [STATUS_W-1:0] err_code_reg, err_code_next;
    logic [CNT_W-1:0]    err_pos_reg, err_pos_next;
    logic                open_bad_reg, open_bad_next;
    logic [CNT_W-1:0]    text_start_reg, text_start_next;
    logic [CNT_W-1:0]    pad_pos_reg, pad_pos_next;

    // Result stage
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    offset_reg;

    logic                advance;
    logic                step;
    logic                load;
    logic [CNT_W-1:0]    text_pos;
    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]    res_offset;
    char_class_t         cls_cur;
    char_class_t         cls_txt;

    // Classify the incoming byte (structure) and the delayed byte (text)
    ewv_classify u_cls_cur (.ch(s1_byte_reg), .cls(cls_cur));
    ewv_classify u_cls_txt (.ch(d1_reg),      .cls(cls_txt));

    // Handshake: a non-last byte never needs the result slot
    assign advance = !s1_last_reg || !out_valid_reg || result_ch.ready;
    assign step    = s1_valid_reg && advance;
    assign load    = step && s1_last_reg;
    assign word_ch.ready = !s1_valid_reg || advance;

    assign text_pos = cnt_reg - CNT_W'(2);

    // Parser next state and end-of-word result
    always_comb
    begin
        cnt_next        = cnt_reg;
        d0_next         = d0_reg;
        d1_next         = d1_reg;
        phase_next      = phase_reg;
        b64_next        = b64_reg;
        pad_next        = pad_reg;
        esc_next        = esc_reg;
        mod4_next       = mod4_reg;
        err_code_next   = err_code_reg;
        err_pos_next    = err_pos_reg;
        open_bad_next   = open_bad_reg;
        text_start_next = text_start_reg;
        pad_pos_next    = pad_pos_reg;

        if (cnt_reg < MAX_CNT)
        begin
            if (phase_reg == PH_TEXT && cnt_reg >= CNT_W'(2) && text_pos >= text_start_reg)
            begin
                // Text byte, checked once it cannot be part of the closing "?="
                if (!b64_reg)
                begin
                    if (esc_reg != 2'd0)
                    begin
                        if (cls_txt.hex)
                        begin
                            esc_next = esc_reg - 2'd1;
                        end
                        else
                        begin
                            err_code_next = ST_Q_HEX;
                            err_pos_next  = text_pos - CNT_W'(3) + CNT_W'(esc_reg);
                            phase_next    = PH_HALT;
                        end
                    end
                    else if (cls_txt.equal)
                    begin
                        esc_next = 2'd2;
                    end
                    else if (!cls_txt.qtext)
                    begin
                        err_code_next = ST_TEXT_BAD;
                        err_pos_next  = text_pos;
                        phase_next    = PH_HALT;
                    end
                end
                else
                begin
                    if (cls_txt.equal)
                    begin
                        if (pad_reg == 2'd0)
                        begin
                            pad_pos_next = text_pos;
                        end
                        if (pad_reg != 2'd3)
                        begin
                            pad_next = pad_reg + 2'd1;
                        end
                        mod4_next = mod4_reg + 2'd1;
                    end
                    else if (pad_reg != 2'd0)
                    begin
                        err_code_next = ST_B_PADDING;
                        err_pos_next  = text_pos;
                        phase_next    = PH_HALT;
                    end
                    else if (!cls_txt.b64)
                    begin
                        err_code_next = ST_B_CHAR;
                        err_pos_next  = text_pos;
                        phase_next    = PH_HALT;
                    end
                    else
                    begin
                        mod4_next = mod4_reg + 2'd1;
                    end
                end
            end
            else if (phase_reg < PH_TEXT)
            begin
                // Header structure on the current byte
                unique case (phase_reg)
                    PH_OPEN:
                    begin
                        if (cnt_reg == CNT_W'(0) && !cls_cur.equal)
                        begin
                            open_bad_next = 1'b1;
                        end
                        if (cnt_reg == CNT_W'(1))
                        begin
                            if (!cls_cur.qmark)
                            begin
                                open_bad_next = 1'b1;
                            end
                            phase_next = PH_CS_FIRST;
                        end
                    end
                    PH_CS_FIRST:
                    begin
                        if (cls_cur.qmark)
                        begin
                            err_code_next = ST_CHARSET_EMPTY;
                            err_pos_next  = cnt_reg;
                            phase_next    = PH_HALT;
                        end
                        else if (!cls_cur.tok)
                        begin
                            err_code_next = ST_CHARSET_BAD;
                            err_pos_next  = cnt_reg;
                            phase_next    = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_CS_REST;
                        end
                    end
                    PH_CS_REST:
                    begin
                        if (cls_cur.qmark)
                        begin
                            phase_next = PH_ENC;
                        end
                        else if (!cls_cur.tok)
                        begin
                            err_code_next = ST_CHARSET_BAD;
                            err_pos_next  = cnt_reg;
                            phase_next    = PH_HALT;
                        end
                    end
                    PH_ENC:
                    begin
                        if (cls_cur.enc_q)
                        begin
                            b64_next   = 1'b0;
                            phase_next = PH_ENC_DELIM;
                        end
                        else if (cls_cur.enc_b)
                        begin
                            b64_next   = 1'b1;
                            phase_next = PH_ENC_DELIM;
                        end
                        else
                        begin
                            err_code_next = ST_BAD_ENCODING;
                            err_pos_next  = cnt_reg;
                            phase_next    = PH_HALT;
                        end
                    end
                    PH_ENC_DELIM:
                    begin
                        if (cls_cur.qmark)
                        begin
                            phase_next      = PH_TEXT;
                            text_start_next = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            err_code_next = ST_NO_ENC_DELIM;
                            err_pos_next  = cnt_reg;
                            phase_next    = PH_HALT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            d1_next = d0_reg;
            d0_next = s1_byte_reg;
        end

        // Saturating byte counter
        if (cnt_reg <= MAX_CNT)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        // Final verdict, in priority order
        res_status = ST_OK;
        res_offset = '0;
        priority if (cnt_next > MAX_CNT)
        begin
            res_status = ST_TOO_LONG;
            res_offset = MAX_CNT;
        end
        else if (cnt_next < CNT_W'(2) || open_bad_next)
        begin
            res_status = ST_NO_OPEN;
        end
        else if (d1_next != CH_QMARK || !cls_cur.equal)
        begin
            res_status = ST_NO_CLOSE;
            res_offset = cnt_next - CNT_W'(2);
        end
        else if (err_code_next != ST_OK)
        begin
            res_status = err_code_next;
            res_offset = err_pos_next;
        end
        else if (phase_next == PH_CS_FIRST)
        begin
            res_status = ST_CHARSET_EMPTY;
            res_offset = cnt_next;
        end
        else if (phase_next == PH_CS_REST)
        begin
            res_status = ST_NO_CS_DELIM;
            res_offset = cnt_next;
        end
        else if (phase_next == PH_ENC)
        begin
            res_status = ST_BAD_ENCODING;
            res_offset = cnt_next;
        end
        else if (phase_next == PH_ENC_DELIM)
        begin
            res_status = ST_NO_ENC_DELIM;
            res_offset = cnt_next;
        end
        else if (text_start_next >= cnt_next - CNT_W'(2))
        begin
            res_status = ST_TEXT_EMPTY;
            res_offset = text_start_next;
        end
        else if (!b64_next)
        begin
            if (esc_next != 2'd0)
            begin
                res_status = ST_Q_HEX;
                res_offset = cnt_next - CNT_W'(5) + CNT_W'(esc_next);
            end
        end
        else if (pad_next > 2'd2)
        begin
            res_status = ST_B_PADDING;
            res_offset = pad_pos_next;
        end
        else if (mod4_next != 2'd0)
        begin
            res_status = ST_B_LENGTH;
            res_offset = cnt_next - CNT_W'(2);
        end
        else
        begin
            // Well-formed base64 word
            res_status = ST_OK;
        end
    end

    // Input stage, parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_byte_reg    <= '0;
            s1_last_reg    <= 1'b0;
            cnt_reg        <= '0;
            d0_reg         <= '0;
            d1_reg         <= '0;
            phase_reg      <= PH_OPEN;
            b64_reg        <= 1'b0;
            pad_reg        <= '0;
            esc_reg        <= '0;
            mod4_reg       <= '0;
            err_code_reg   <= ST_OK;
            err_pos_reg    <= '0;
            open_bad_reg   <= 1'b0;
            text_start_reg <= '0;
            pad_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            offset_reg     <= '0;
        end
        else
        begin
            // Input register
            if (word_ch.valid && word_ch.ready)
            begin
                s1_valid_reg <= 1'b1;
                s1_byte_reg  <= word_ch.word_byte;
                s1_last_reg  <= word_ch.last_byte;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Parser state: cleared after each word
            if (step)
            begin
                if (s1_last_reg)
                begin
                    cnt_reg        <= '0;
                    d0_reg         <= '0;
                    d1_reg         <= '0;
                    phase_reg      <= PH_OPEN;
                    b64_reg        <= 1'b0;
                    pad_reg        <= '0;
                    esc_reg        <= '0;
                    mod4_reg       <= '0;
                    err_code_reg   <= ST_OK;
                    err_pos_reg    <= '0;
                    open_bad_reg   <= 1'b0;
                    text_start_reg <= '0;
                    pad_pos_reg    <= '0;
                end
                else
                begin
                    cnt_reg        <= cnt_next;
                    d0_reg         <= d0_next;
                    d1_reg         <= d1_next;
                    phase_reg      <= phase_next;
                    b64_reg        <= b64_next;
                    pad_reg        <= pad_next;
                    esc_reg        <= esc_next;
                    mod4_reg       <= mod4_next;
                    err_code_reg   <= err_code_next;
                    err_pos_reg    <= err_pos_next;
                    open_bad_reg   <= open_bad_next;
                    text_start_reg <= text_start_next;
                    pad_pos_reg    <= pad_pos_next;
                end
            end

            // Result register
            if (load)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= res_status;
                offset_reg    <= res_offset;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.status       = status_reg;
    assign result_ch.error_offset = OFFSET_W'(offset_reg);

    // A new result only comes from the last byte of a word
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result without a last byte");

    // Parser is cleared for the next word once a result is taken in
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cnt_reg == '0 && phase_reg == PH_OPEN && err_code_reg == ST_OK))
        else $error("parser not cleared after word");

    // Byte counter saturates one past the length limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT + CNT_W'(1))
        else $error("byte counter overran");

    // Halted parser always holds a recorded error
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALT) |-> (err_code_reg != ST_OK))
        else $error("halted without an error");

    // An accepted word reports offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OK) |-> (offset_reg == '0))
        else $error("ok result with nonzero offset");

endmodule
